### sv/jkd_pkg.sv
// Shared types, codes, constants and slot tables of the joystick key event detector.
package jkd_pkg;

   // Field and register widths
   localparam int THR_BITS        = 12;
   localparam int HOLD_BITS       = 16;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int KEY_CODE_BITS   = 3;
   localparam int EVENT_KIND_BITS = 2;
   localparam int KEY_COUNT       = 7;

   // Default parameter values
   localparam int DEFAULT_ADC_BITS  = 12;
   localparam int DEFAULT_TIME_BITS = 32;

   // Register reset values
   localparam logic [THR_BITS-1:0]  LOW_THRESHOLD_RESET  = 12'd1000;
   localparam logic [THR_BITS-1:0]  HIGH_THRESHOLD_RESET = 12'd3000;
   localparam logic [HOLD_BITS-1:0] LONG_PRESS_RESET     = 16'd800;

   // Event sets waiting between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LOW_THRESHOLD  = 2'd0,
      REG_HIGH_THRESHOLD = 2'd1,
      REG_LONG_PRESS_MS  = 2'd2
   } csr_index_type;

   typedef enum logic [KEY_CODE_BITS-1:0] {
      KEY_UP    = 3'd0,
      KEY_DOWN  = 3'd1,
      KEY_LEFT  = 3'd2,
      KEY_RIGHT = 3'd3,
      KEY_ENTER = 3'd4,
      KEY_SPACE = 3'd5,
      KEY_MENU  = 3'd6
   } key_code_type;

   typedef enum logic [EVENT_KIND_BITS-1:0] {
      EV_RELEASE = 2'd0,
      EV_PRESS   = 2'd1,
      EV_LONG    = 2'd2
   } event_kind_type;

   // What an event slot emits
   typedef enum logic [1:0] {
      SLOT_EDGE         = 2'd0,
      SLOT_LONG_RELEASE = 2'd1,
      SLOT_LONG         = 2'd2
   } slot_role_type;

   // Event slots in emission order: five plain keys, then edge, long release
   // and long press for space and for menu
   localparam int SLOT_COUNT       = 11;
   localparam int SLOT_INDEX_BITS  = $clog2(SLOT_COUNT);
   localparam int SLOT_SPACE_EDGE  = 5;
   localparam int SLOTS_PER_LONG   = 3;
   localparam int LONG_KEY_COUNT   = 2;

   localparam key_code_type SLOT_KEY [SLOT_COUNT] = '{
      KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_ENTER,
      KEY_SPACE, KEY_SPACE, KEY_SPACE,
      KEY_MENU, KEY_MENU, KEY_MENU
   };

   localparam slot_role_type SLOT_ROLE [SLOT_COUNT] = '{
      SLOT_EDGE, SLOT_EDGE, SLOT_EDGE, SLOT_EDGE, SLOT_EDGE,
      SLOT_EDGE, SLOT_LONG_RELEASE, SLOT_LONG,
      SLOT_EDGE, SLOT_LONG_RELEASE, SLOT_LONG
   };

   // Events caused by one poll: which slots fire, and each key's new level
   typedef struct packed {
      logic [SLOT_COUNT-1:0] mask;
      logic [KEY_COUNT-1:0]  press;
   } event_set_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

endpackage

### sv/jkd_front.sv
// Front end: configuration registers, key classification and per-key state.
module jkd_front #(
   parameter int ADC_BITS  = jkd_pkg::DEFAULT_ADC_BITS,
   parameter int TIME_BITS = jkd_pkg::DEFAULT_TIME_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [jkd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [jkd_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ADC_BITS-1:0]                req_x_sample,
   input  logic [ADC_BITS-1:0]                req_y_sample,
   input  logic                               req_enter_level,
   input  logic                               req_space_level,
   input  logic                               req_menu_level,
   input  logic [TIME_BITS-1:0]               req_now_ms,
   input  jkd_pkg::queue_status_type          q_status,
   output logic                               push_valid,
   output jkd_pkg::event_set_type             push_data
);
   import jkd_pkg::*;

   localparam int CMP_BITS = (ADC_BITS > THR_BITS) ? ADC_BITS : THR_BITS;

   logic [THR_BITS-1:0]  low_threshold_ff, low_threshold_in;
   logic [THR_BITS-1:0]  high_threshold_ff, high_threshold_in;
   logic [HOLD_BITS-1:0] long_press_ff, long_press_in;

   logic [KEY_COUNT-1:0] key_states_ff, key_states_in;
   logic [TIME_BITS-1:0] press_time_ff [LONG_KEY_COUNT];
   logic [TIME_BITS-1:0] press_time_in [LONG_KEY_COUNT];
   logic                 long_done_ff  [LONG_KEY_COUNT];
   logic                 long_done_in  [LONG_KEY_COUNT];

   logic [CMP_BITS-1:0]  x_ext, y_ext, low_ext, high_ext;
   logic [KEY_COUNT-1:0] now_on;
   logic [TIME_BITS-1:0] held_ms [LONG_KEY_COUNT];
   logic                 edge_seen [LONG_KEY_COUNT];
   logic                 pressed [LONG_KEY_COUNT];
   logic                 fire [LONG_KEY_COUNT];
   logic                 accept;
   event_set_type        events;

   // Take an item whenever the queue has room
   assign req_stall = q_status.full;
   assign accept    = req_valid & ~q_status.full;

   // Write configuration registers
   always_comb begin
      low_threshold_in  = low_threshold_ff;
      high_threshold_in = high_threshold_ff;
      long_press_in     = long_press_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_LOW_THRESHOLD:  low_threshold_in  = csr_data[THR_BITS-1:0];
            REG_HIGH_THRESHOLD: high_threshold_in = csr_data[THR_BITS-1:0];
            REG_LONG_PRESS_MS:  long_press_in     = csr_data[HOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Classify axes and buttons into key levels
   always_comb begin
      x_ext    = CMP_BITS'(req_x_sample);
      y_ext    = CMP_BITS'(req_y_sample);
      low_ext  = CMP_BITS'(low_threshold_ff);
      high_ext = CMP_BITS'(high_threshold_ff);
      now_on[KEY_UP]    = y_ext < low_ext;
      now_on[KEY_DOWN]  = y_ext > high_ext;
      now_on[KEY_LEFT]  = x_ext < low_ext;
      now_on[KEY_RIGHT] = x_ext > high_ext;
      now_on[KEY_ENTER] = ~req_enter_level;
      now_on[KEY_SPACE] = ~req_space_level;
      now_on[KEY_MENU]  = ~req_menu_level;
   end

   // Build the event set and the next key state
   always_comb begin
      events.mask   = '0;
      events.press  = now_on;
      key_states_in = now_on;
      for (int i = 0; i < int'(KEY_SPACE); i++) begin
         events.mask[i] = now_on[i] ^ key_states_ff[i];
      end
      for (int l = 0; l < LONG_KEY_COUNT; l++) begin
         edge_seen[l] = now_on[int'(KEY_SPACE) + l] ^ key_states_ff[int'(KEY_SPACE) + l];
         pressed[l]   = edge_seen[l] & now_on[int'(KEY_SPACE) + l];
         press_time_in[l] = pressed[l] ? req_now_ms : press_time_ff[l];
         held_ms[l]   = req_now_ms - press_time_in[l];
         fire[l]      = now_on[int'(KEY_SPACE) + l] & ~(long_done_ff[l] & ~pressed[l])
                        & (held_ms[l] > TIME_BITS'(long_press_ff));
         long_done_in[l] = (long_done_ff[l] & ~pressed[l]) | fire[l];
         // Release after a long press stays silent
         events.mask[SLOT_SPACE_EDGE + SLOTS_PER_LONG * l] = pressed[l]
            | (edge_seen[l] & ~now_on[int'(KEY_SPACE) + l] & ~long_done_ff[l]);
         events.mask[SLOT_SPACE_EDGE + SLOTS_PER_LONG * l + 1] = fire[l];
         events.mask[SLOT_SPACE_EDGE + SLOTS_PER_LONG * l + 2] = fire[l];
      end
   end

   // Hand polls with at least one event to the queue
   assign push_valid = accept & (|events.mask);
   assign push_data  = events;

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         low_threshold_ff  <= LOW_THRESHOLD_RESET;
         high_threshold_ff <= HIGH_THRESHOLD_RESET;
         long_press_ff     <= LONG_PRESS_RESET;
      end else begin
         low_threshold_ff  <= low_threshold_in;
         high_threshold_ff <= high_threshold_in;
         long_press_ff     <= long_press_in;
      end
   end

   // Advance key state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         key_states_ff <= '0;
         for (int l = 0; l < LONG_KEY_COUNT; l++) begin
            press_time_ff[l] <= '0;
            long_done_ff[l]  <= 1'b0;
         end
      end else if (accept) begin
         key_states_ff <= key_states_in;
         for (int l = 0; l < LONG_KEY_COUNT; l++) begin
            press_time_ff[l] <= press_time_in[l];
            long_done_ff[l]  <= long_done_in[l];
         end
      end
   end

endmodule

### sv/jkd_queue.sv
// Short queue of event sets between the front and back ends.
module jkd_queue #(
   parameter int WIDTH = $bits(jkd_pkg::event_set_type),
   parameter int DEPTH = jkd_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output jkd_pkg::queue_status_type status
);
   import jkd_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == COUNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/jkd_back.sv
// Back end: emit a set's events to the output register, one per cycle unless stalled.
module jkd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  jkd_pkg::queue_status_type           q_status,
   input  jkd_pkg::event_set_type              q_data,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [jkd_pkg::KEY_CODE_BITS-1:0]   rsp_key_code,
   output logic [jkd_pkg::EVENT_KIND_BITS-1:0] rsp_event_kind,
   output logic                                rsp_last_event,
   output jkd_pkg::back_status_type            status
);
   import jkd_pkg::*;

   logic [SLOT_COUNT-1:0]      cur_mask_ff, cur_mask_in;
   logic [KEY_COUNT-1:0]       cur_press_ff, cur_press_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [KEY_CODE_BITS-1:0]   rsp_key_ff, rsp_key_in;
   logic [EVENT_KIND_BITS-1:0] rsp_kind_ff, rsp_kind_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [SLOT_INDEX_BITS-1:0] sel;
   logic [SLOT_COUNT-1:0]      remain;
   logic                       out_free, emit;
   key_code_type               sel_key;
   event_kind_type             sel_kind;

   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign emit        = out_free & (|cur_mask_ff);
   assign status.busy = |cur_mask_ff;

   // Pick the lowest pending slot
   always_comb begin
      sel = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (cur_mask_ff[i]) begin
            sel = SLOT_INDEX_BITS'(i);
         end
      end
      remain  = cur_mask_ff & ~(SLOT_COUNT'(1) << sel);
      sel_key = SLOT_KEY[sel];
   end

   // Decode the event kind of the chosen slot
   always_comb begin
      case (SLOT_ROLE[sel])
         SLOT_EDGE:         sel_kind = cur_press_ff[sel_key] ? EV_PRESS : EV_RELEASE;
         SLOT_LONG_RELEASE: sel_kind = EV_RELEASE;
         SLOT_LONG:         sel_kind = EV_LONG;
         default:           sel_kind = EV_RELEASE;
      endcase
   end

   // Load the next set when idle or on the last event of the current one
   assign q_pop = ~q_status.empty & (~(|cur_mask_ff) | (emit & ~(|remain)));

   always_comb begin
      cur_mask_in  = cur_mask_ff;
      cur_press_in = cur_press_ff;
      if (q_pop) begin
         cur_mask_in  = q_data.mask;
         cur_press_in = q_data.press;
      end else if (emit) begin
         cur_mask_in = remain;
      end
   end

   // Fill or drain the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = sel_key;
         rsp_kind_in  = sel_kind;
         rsp_last_in  = ~(|remain);
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_mask_ff  <= cur_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_press_ff <= cur_press_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_code   = rsp_key_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_last_event = rsp_last_ff;

endmodule

### sv/joystick_key_event_detector.sv
// Top level of the joystick key event detector: front end, event queue and back end.
//
// Each poll item carries two axis samples, three active-low button levels and a
// millisecond timestamp. The front end takes one poll per cycle while the two-entry
// event queue has room, classifies the keys, updates key and long-press state and
// queues the set of events the poll causes (zero to nine). The back end emits those
// events one per cycle while rsp_stall is low, in key-code order, with last_event on
// the final one, through an output register. A poll with no events is accepted and
// produces nothing. The back end, at one event per cycle when not stalled, sets the
// sustained rate. Configuration registers take effect for polls accepted after the
// write.
module joystick_key_event_detector #(
   parameter int ADC_BITS  = jkd_pkg::DEFAULT_ADC_BITS,
   parameter int TIME_BITS = jkd_pkg::DEFAULT_TIME_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [jkd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [jkd_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ADC_BITS-1:0]                 req_x_sample,
   input  logic [ADC_BITS-1:0]                 req_y_sample,
   input  logic                                req_enter_level,
   input  logic                                req_space_level,
   input  logic                                req_menu_level,
   input  logic [TIME_BITS-1:0]                req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [jkd_pkg::KEY_CODE_BITS-1:0]   rsp_key_code,
   output logic [jkd_pkg::EVENT_KIND_BITS-1:0] rsp_event_kind,
   output logic                                rsp_last_event
);
   import jkd_pkg::*;

   queue_status_type q_status;
   back_status_type  back_status;
   event_set_type    push_data, pop_data;
   logic             push_valid, q_pop;

   jkd_front #(
      .ADC_BITS  (ADC_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_sample    (req_x_sample),
      .req_y_sample    (req_y_sample),
      .req_enter_level (req_enter_level),
      .req_space_level (req_space_level),
      .req_menu_level  (req_menu_level),
      .req_now_ms      (req_now_ms),
      .q_status        (q_status),
      .push_valid      (push_valid),
      .push_data       (push_data)
   );

   jkd_queue #(
      .WIDTH ($bits(event_set_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   jkd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_data         (pop_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_code   (rsp_key_code),
      .rsp_event_kind (rsp_event_kind),
      .rsp_last_event (rsp_last_event),
      .status         (back_status)
   );

`ifndef NO_ASSERTIONS
   // Queue cannot be full and empty at once
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("event queue reports full and empty together");

   // A non-final event means more events of the same poll are pending
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_event) |-> back_status.busy)
      else $error("non-final event shown with no events left in the back end");

   // Long presses come only from space and menu
   a_long_keys: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_LONG) |->
         (rsp_key_code == KEY_SPACE || rsp_key_code == KEY_MENU))
      else $error("long press event on a key without long-press tracking");
`endif

endmodule
